@@ hw/rtl/a2b_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared widths, tangent table and stage types for the bisection atan2.
// ----------------------------------------------------------------------------
package a2b_pkg;

    localparam int BISECT_STEPS = 9;
    localparam int COORD_WIDTH  = 16;
    localparam int ANGLE_WIDTH  = 12;
    localparam int TAN_FRAC     = 16;

    localparam int ROM_SIZE = 1 << BISECT_STEPS;
    localparam int IDX_W    = BISECT_STEPS;
    localparam int MAG_W    = COORD_WIDTH;
    localparam int LHS_W    = MAG_W + TAN_FRAC;

    localparam int QUARTER_CODE = 1 << (ANGLE_WIDTH - 2);
    localparam int HALF_CODE    = 1 << (ANGLE_WIDTH - 1);
    localparam int NATIVE_STEPS = ANGLE_WIDTH - 3;
    localparam int MID_UP       = (BISECT_STEPS <= NATIVE_STEPS) ?
                                  (NATIVE_STEPS - BISECT_STEPS) : 0;
    localparam int MID_DN       = (BISECT_STEPS > NATIVE_STEPS) ?
                                  (BISECT_STEPS - NATIVE_STEPS) : 0;
    localparam int MID_W        = BISECT_STEPS + 1 + MID_UP;

    localparam int LATENCY = BISECT_STEPS + 2;

    localparam real PI_VAL    = 3.14159265358979323846;
    localparam real NODE_STEP = PI_VAL / real'(longint'(1) << (BISECT_STEPS + 1));

    function automatic longint tan_q16(int m);
        real a;
        a = NODE_STEP * real'(m);
        return longint'($tan(a) * real'(longint'(1) << TAN_FRAC));
    endfunction

    localparam int TAN_W  = $clog2(tan_q16(ROM_SIZE - 1) + 1);
    localparam int PROD_W = MAG_W + TAN_W;
    localparam int CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

    typedef logic [TAN_W-1:0] t_tan_rom [ROM_SIZE];

    function automatic t_tan_rom build_tan_rom();
        t_tan_rom rom;
        for (int m = 0; m < ROM_SIZE; m++) begin
            rom[m] = TAN_W'(tan_q16(m));
        end
        return rom;
    endfunction

    localparam t_tan_rom TAN_ROM = build_tan_rom();

    typedef struct packed {
        logic flip_x;
        logic flip_y;
        logic on_axis;
        logic vertical;
    } t_meta;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        t_meta            meta;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] step;
        logic [TAN_W-1:0] tan;
    } t_stage;

endpackage

@@ hw/rtl/a2b_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_fold
// Folds the vector into the first quadrant and seeds the bisection chain.
// ----------------------------------------------------------------------------
module a2b_fold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [a2b_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [a2b_pkg::COORD_WIDTH-1:0] i_y_coord,
    output logic                                   o_valid,
    output a2b_pkg::t_stage                        o_stage
);
    import a2b_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage.meta.flip_x = i_x_coord[COORD_WIDTH-1];
        n_stage.meta.flip_y = i_y_coord[COORD_WIDTH-1];
        n_stage.ax = i_x_coord[COORD_WIDTH-1] ? (~i_x_coord + 1'b1) : i_x_coord;
        n_stage.ay = i_y_coord[COORD_WIDTH-1] ? (~i_y_coord + 1'b1) : i_y_coord;
        n_stage.meta.vertical = (i_x_coord == '0);
        n_stage.meta.on_axis  = (i_x_coord == '0) || (i_y_coord == '0);
        n_stage.lo   = '0;
        n_stage.step = IDX_W'(ROM_SIZE / 2);
        n_stage.tan  = TAN_ROM[IDX_W'(ROM_SIZE / 2)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

@@ hw/rtl/a2b_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_cell
// One bisection step: compare against the node tangent, narrow the interval
// and fetch the tangent of the next node.
// ----------------------------------------------------------------------------
module a2b_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  a2b_pkg::t_stage i_stage,
    output logic            o_valid,
    output a2b_pkg::t_stage o_stage
);
    import a2b_pkg::*;

    logic             r_valid;
    t_stage           r_stage;
    t_stage           n_stage;
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] step_next;
    logic [PROD_W-1:0] prod;
    logic [LHS_W-1:0]  lhs;
    logic              below;
    logic [TAN_W-1:0]  tan_lo;
    logic [TAN_W-1:0]  tan_hi;

    always_comb begin
        mid       = i_stage.lo + i_stage.step;
        step_next = i_stage.step >> 1;
        prod      = PROD_W'(i_stage.ax) * PROD_W'(i_stage.tan);
        lhs       = {i_stage.ay, {TAN_FRAC{1'b0}}};
        below     = CMP_W'(lhs) < CMP_W'(prod);
        tan_lo    = TAN_ROM[i_stage.lo + step_next];
        tan_hi    = TAN_ROM[mid + step_next];

        n_stage      = i_stage;
        n_stage.step = step_next;
        n_stage.lo   = below ? i_stage.lo : mid;
        n_stage.tan  = below ? tan_lo : tan_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

@@ hw/rtl/a2b_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_finish
// Turns the final interval into a code, unfolds the quadrant and registers
// the result beat.
// ----------------------------------------------------------------------------
module a2b_finish (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  a2b_pkg::t_stage                   i_stage,
    output logic                              o_strobe,
    output logic [a2b_pkg::ANGLE_WIDTH-1:0]   o_angle_code
);
    import a2b_pkg::*;

    logic                   r_strobe;
    logic [ANGLE_WIDTH-1:0] r_angle_code;
    logic [ANGLE_WIDTH-1:0] n_angle_code;
    logic [MID_W-1:0]       mid_full;
    logic [ANGLE_WIDTH-1:0] base;
    logic [ANGLE_WIDTH-1:0] folded;

    always_comb begin
        mid_full = MID_W'({i_stage.lo, 1'b1}) << MID_UP;
        base     = ANGLE_WIDTH'(mid_full >> MID_DN);
        if (i_stage.meta.vertical) begin
            base = ANGLE_WIDTH'(QUARTER_CODE);
        end else if (i_stage.meta.on_axis) begin
            base = '0;
        end
        folded = i_stage.meta.flip_x ? (ANGLE_WIDTH'(HALF_CODE) - base) : base;
        n_angle_code = i_stage.meta.flip_y ? (ANGLE_WIDTH'(0) - folded) : folded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle_code <= n_angle_code;
    end

    assign o_strobe     = r_strobe;
    assign o_angle_code = r_angle_code;

endmodule

@@ hw/rtl/atan2_by_bisection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_by_bisection
// Angle of a signed vector as a code of 4096 per turn, clockwise from +x.
//
// Input: drive i_x_coord and i_y_coord and raise start; the beat is taken
// at every clock edge with start high and busy low. busy never rises, so
// a new vector may be offered in every cycle.
// Output: each result appears on o_angle_code for exactly one cycle with
// o_strobe high, after it passes the fold, cell and finish registers.
// Results come out in input order; the receiver cannot stall them.
// Throughput is one vector per cycle: a fold stage, one cell per bisection
// step (one multiply and compare each) and an output register.
// Latency is set by the length of the cell chain.
// Reset (i_rst_n low, synchronous) drops every beat in flight; no strobe
// follows for vectors taken before reset.
// ----------------------------------------------------------------------------
module atan2_by_bisection (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [a2b_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [a2b_pkg::COORD_WIDTH-1:0] i_y_coord,
    output logic                                   o_strobe,
    output logic [a2b_pkg::ANGLE_WIDTH-1:0]        o_angle_code
);
    import a2b_pkg::*;

    logic   w_valid [BISECT_STEPS+1];
    t_stage w_stage [BISECT_STEPS+1];

    assign busy = 1'b0;

    a2b_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (w_valid[0]),
        .o_stage   (w_stage[0])
    );

    for (genvar g = 0; g < BISECT_STEPS; g++) begin : g_cell
        a2b_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    a2b_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[BISECT_STEPS]),
        .i_stage      (w_stage[BISECT_STEPS]),
        .o_strobe     (o_strobe),
        .o_angle_code (o_angle_code)
    );

endmodule

@@ hw/rtl/a2b_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_checker
// Port-level checks of beat timing and quadrant placement.
// ----------------------------------------------------------------------------
module a2b_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic signed [a2b_pkg::COORD_WIDTH-1:0] i_x_coord,
    input logic signed [a2b_pkg::COORD_WIDTH-1:0] i_y_coord,
    input logic                                   o_strobe,
    input logic [a2b_pkg::ANGLE_WIDTH-1:0]        o_angle_code
);
    import a2b_pkg::*;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_strobe)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted beat");

    a_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_x_coord == 0 && i_y_coord > 0
        |-> ##LATENCY o_angle_code == ANGLE_WIDTH'(QUARTER_CODE))
        else $error("downward vector not a quarter turn");

    a_first_quadrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_x_coord > 0 && i_y_coord >= 0
        |-> ##LATENCY o_angle_code < ANGLE_WIDTH'(QUARTER_CODE))
        else $error("first quadrant vector left its quadrant");

endmodule

bind atan2_by_bisection a2b_checker u_checker (.*);

@@ tb/atan2_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_checker
// Watches the vector and angle channels of atan2_by_bisection. It works out
// the angle code of every vector taken, queues it, and compares each strobed
// result in order with the oldest queued code. It builds its own Q16 tangent
// table from fixed-point sine and cosine series.
// ----------------------------------------------------------------------------
module atan2_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_busy,
    input  logic signed [a2b_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [a2b_pkg::COORD_WIDTH-1:0] i_y_coord,
    input  logic                                   i_strobe,
    input  logic [a2b_pkg::ANGLE_WIDTH-1:0]        i_angle_code,
    input  logic                                   i_final_check,
    output logic                                   o_drained,
    output int                                     o_fail_count
);

    localparam int COORD_W  = a2b_pkg::COORD_WIDTH;
    localparam int ANGLE_W  = a2b_pkg::ANGLE_WIDTH;
    localparam int STEPS    = a2b_pkg::BISECT_STEPS;
    localparam int ROM_N    = 1 << STEPS;
    localparam int Q_FRAC   = 16;
    localparam int BASE_STEPS   = ANGLE_W - 3;
    localparam int QUARTER_TURN = 1 << (ANGLE_W - 2);
    localparam int HALF_TURN    = 1 << (ANGLE_W - 1);
    localparam int FULL_TURN    = 1 << ANGLE_W;
    localparam bit [63:0] Q62_ONE     = 64'h4000000000000000;
    localparam bit [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    bit [31:0]                tan_rom [ROM_N];
    logic [ANGLE_W-1:0]       angle_q [$];
    logic [ANGLE_W-1:0]       want;
    int                       fail_count = 0;
    bit                       final_seen = 1'b0;

    assign o_fail_count = fail_count;

    function automatic bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
        bit [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // odd selects sine, else cosine; angle in Q62 radians up to a quarter turn
    function automatic bit [63:0] trig_series(bit [63:0] ang, bit odd);
        bit [63:0] sq;
        bit [63:0] term;
        bit [63:0] sum;
        bit [63:0] n;
        bit        neg;
        sq   = q62_mul(ang, ang);
        term = odd ? ang : Q62_ONE;
        sum  = term;
        n    = odd ? 64'd1 : 64'd0;
        neg  = 1'b1;
        while (term != 0 && n < 80) begin
            term = q62_mul(term, sq) / ((n + 1) * (n + 2));
            n    = n + 2;
            sum  = neg ? sum - term : sum + term;
            neg  = !neg;
        end
        return sum;
    endfunction

    function automatic bit [31:0] tan_node(int k);
        bit [63:0]  base;
        bit [63:0]  rest;
        bit [63:0]  ang;
        bit [63:0]  s;
        bit [63:0]  c;
        bit [127:0] q;
        base = HALF_PI_Q62 >> STEPS;
        rest = HALF_PI_Q62 & 64'(ROM_N - 1);
        ang  = base * 64'(k) + ((rest * 64'(k)) >> STEPS);
        s    = trig_series(ang, 1'b1);
        c    = trig_series(ang, 1'b0);
        if (c == 0) c = 1;
        q = ({64'd0, s} << 17) / {64'd0, c};
        q = (q + 1) >> 1;
        return q[31:0];
    endfunction

    function automatic int quadrant_code(longint ax, longint ay);
        int     lo;
        int     hi;
        int     m;
        int     mid;
        longint lhs;
        lo  = 0;
        hi  = ROM_N;
        lhs = ay << Q_FRAC;
        for (int i = 0; i < STEPS; i++) begin
            m = (lo + hi) >> 1;
            if (lhs < ax * longint'(tan_rom[m & (ROM_N - 1)])) hi = m;
            else lo = m;
        end
        mid = 2 * lo + 1;
        if (STEPS <= BASE_STEPS) return mid << (BASE_STEPS - STEPS);
        return mid >> (STEPS - BASE_STEPS);
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_of(logic signed [COORD_W-1:0] x,
                                                   logic signed [COORD_W-1:0] y);
        longint sx;
        longint sy;
        longint ax;
        longint ay;
        int     code;
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        if (ax == 0) code = QUARTER_TURN;
        else if (ay == 0) code = 0;
        else code = quadrant_code(ax, ay);
        if (sx < 0) code = HALF_TURN - code;
        if (sy < 0) code = FULL_TURN - code;
        return code[ANGLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    initial begin
        tan_rom[0] = 0;
        for (int k = 1; k < ROM_N; k++) tan_rom[k] = tan_node(k);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            angle_q.delete();
            o_drained <= 1'b1;
        end else begin
            if (i_start && !i_busy) begin
                angle_q.push_back(angle_of(i_x_coord, i_y_coord));
            end
            if (i_strobe !== 1'b0) begin
                if (angle_q.size() == 0) begin
                    report_mismatch($sformatf("angle %0d with no vector pending",
                                              i_angle_code));
                end else begin
                    want = angle_q.pop_front();
                    if (i_strobe !== 1'b1 || i_angle_code !== want) begin
                        report_mismatch($sformatf("angle_code %0d, expected %0d",
                                                  i_angle_code, want));
                    end
                end
            end
            if (i_final_check && !final_seen) begin
                final_seen = 1'b1;
                while (angle_q.size() > 0) begin
                    want = angle_q.pop_front();
                    report_mismatch($sformatf("angle %0d never came out", want));
                end
            end
            o_drained <= (angle_q.size() == 0);
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives signed vectors into atan2_by_bisection: a directed set of axes,
// diagonals and extreme coordinates, then random vectors weighted toward
// bisection node boundaries, small and extreme magnitudes. The sender idles
// at random except for one long stretch. atan2_checker does the comparing;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  COORD_W      = a2b_pkg::COORD_WIDTH;
    localparam int  RANDOM_BEATS = 1030;
    localparam int  STALL_LIMIT  = 2000;
    localparam int  IDLE_PCT     = 37;
    localparam real HALF_PI      = 1.57079632679489661923;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_x_coord = '0;
    logic signed [COORD_W-1:0] i_y_coord = '0;
    logic                      o_strobe;
    logic [a2b_pkg::ANGLE_WIDTH-1:0] o_angle_code;
    logic                      final_check = 1'b0;
    logic                      drained;
    int                        fail_count;
    int                        stall_cycles = 0;
    bit                        idle_on = 1'b1;

    int corner_x [23] = '{0, 1, 0, -1, 0, 32767, -32768, 0, 0, -32768, 32767, -32768,
                          32767, 1, -1, 1, -1, 32767, 1, -32768, 1, 3, -5};
    int corner_y [23] = '{0, 0, 1, 0, -1, 0, 0, 32767, -32768, -32768, 32767, 32767,
                          -32768, 1, -1, -1, 1, 1, 32767, 1, -32768, 4, 12};

    atan2_by_bisection dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_strobe     (o_strobe),
        .o_angle_code (o_angle_code)
    );

    atan2_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_strobe      (o_strobe),
        .i_angle_code  (o_angle_code),
        .i_final_check (final_check),
        .o_drained     (drained),
        .o_fail_count  (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic drive_vector(input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
        i_x_coord <= x;
        i_y_coord <= y;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
    endtask

    // hold the sender until every queued angle has come out
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (!drained) @(posedge i_clk);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    task automatic pick_vector(output logic signed [COORD_W-1:0] x,
                               output logic signed [COORD_W-1:0] y);
        int  kind;
        int  ax;
        int  ay;
        int  m;
        real t;
        kind = $urandom_range(99);
        if (kind < 35) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else if (kind < 50) begin
            x = COORD_W'(int'($urandom_range(16)) - 8);
            y = COORD_W'(int'($urandom_range(16)) - 8);
        end else if (kind < 70) begin
            // land near a tangent node so the compare sits on its boundary
            m = $urandom_range(1, (1 << a2b_pkg::BISECT_STEPS) - 1);
            t = $tan(HALF_PI * m / real'(1 << a2b_pkg::BISECT_STEPS));
            if (t <= 1.0) begin
                ax = $urandom_range(1, 32767);
                ay = $rtoi(ax * t) + int'($urandom_range(2)) - 1;
            end else begin
                ay = $urandom_range(1, 32767);
                ax = $rtoi(ay / t) + int'($urandom_range(2)) - 1;
            end
            if (ax < 1) ax = 1;
            if (ay < 1) ay = 1;
            if (ax > 32767) ax = 32767;
            if (ay > 32767) ay = 32767;
            x = COORD_W'($urandom_range(1) ? -ax : ax);
            y = COORD_W'($urandom_range(1) ? -ay : ay);
        end else if (kind < 80) begin
            x = COORD_W'(int'($urandom_range(2)) - 1);
            y = COORD_W'($urandom);
            if ($urandom_range(1)) begin
                y = x;
                x = COORD_W'($urandom);
            end
        end else if (kind < 90) begin
            ax = $urandom_range(1, 32768);
            x = COORD_W'($urandom_range(1) ? -ax : ax);
            y = COORD_W'($urandom_range(1) ? -ax : ax);
        end else begin
            x = COORD_W'(pick_extreme());
            y = COORD_W'(pick_extreme());
        end
    endtask

    initial begin
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 23; k++) begin
            drive_vector(COORD_W'(corner_x[k]), COORD_W'(corner_y[k]));
        end
        wait_drained();
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            idle_on = !(n >= 400 && n < 600);
            if (n == 700) wait_drained();
            pick_vector(vx, vy);
            drive_vector(vx, vy);
        end
        wait_drained();
        repeat (a2b_pkg::LATENCY + 4) @(posedge i_clk);
        final_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/a2b_pkg.sv
hw/rtl/a2b_fold.sv
hw/rtl/a2b_cell.sv
hw/rtl/a2b_finish.sv
hw/rtl/atan2_by_bisection.sv
hw/rtl/a2b_checker.sv
tb/atan2_checker.sv
tb/tb_top.sv
